// ===== design/slirf_pkg.sv =====
// ----------------------------------------------------------------------------
// slirf_pkg
// Shared types and constants of the sorted list block.
// ----------------------------------------------------------------------------
package slirf_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   ins_en;
    logic   rm_en;
    logic   found;
  } cell_cmd_t;

endpackage

// ===== design/slirf_cell.sv =====
// ----------------------------------------------------------------------------
// slirf_cell
// One slot of the sorted row: holds one entry, compares it with the operand
// and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module slirf_cell (
  input  logic                clk,
  input  slirf_pkg::cell_cmd_t cmd,
  input  logic                valid,
  input  logic                prev_ins,
  input  slirf_pkg::value_t   prev_entry,
  input  slirf_pkg::value_t   next_entry,
  output slirf_pkg::value_t   entry,
  output logic                ins,
  output logic                eq
);
  import slirf_pkg::*;

  value_t entry_r;
  value_t entry_nxt;
  logic   ge;

  assign entry = entry_r;
  assign ins   = !valid || (entry_r > cmd.value);
  assign ge    = valid && (entry_r >= cmd.value);
  assign eq    = valid && (entry_r == cmd.value);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en) begin
      if (prev_ins) begin
        entry_nxt = prev_entry;
      end else if (ins) begin
        entry_nxt = cmd.value;
      end
    end else if (cmd.rm_en && cmd.found && ge) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== design/sorted_list_insert_remove_find_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_find_top
// Sorted store of signed words with insert, remove and find on a row of cells.
// Result: strobe rises in the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, each cell compares and
// shifts in the same cycle.
// Reset: synchronous active-low rst_n empties the store and clears the strobe.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_find_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_operation,
  input  logic signed [slirf_pkg::VALUE_W-1:0]  in_value,
  output logic                                  out_strobe,
  output logic [1:0]                            out_status,
  output logic [slirf_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import slirf_pkg::*;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   strobe_r;
  status_t                status_r;
  status_t                status_nxt;
  logic [COUNT_OUT_W-1:0] ecount_r;

  cell_cmd_t              cmd;
  op_t                    op;
  logic                   full;
  logic                   found;
  logic [CAPACITY-1:0]    valid;
  logic [CAPACITY-1:0]    ins;
  logic [CAPACITY-1:0]    eq;
  value_t                 entry [CAPACITY];

  assign busy  = 1'b0;
  assign op    = op_t'(in_operation);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign found = |eq;

  assign cmd.value  = in_value;
  assign cmd.found  = found;
  assign cmd.ins_en = start && (op == OP_INSERT) && !full;
  assign cmd.rm_en  = start && (op == OP_REMOVE) && found;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic   p_ins;
      value_t p_entry;
      value_t n_entry;

      assign valid[g] = (count_r > CNT_W'(g));

      if (g == 0) begin : g_head
        assign p_ins   = 1'b0;
        assign p_entry = entry[g];
      end else begin : g_body
        assign p_ins   = ins[g-1];
        assign p_entry = entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign n_entry = entry[g];
      end else begin : g_mid
        assign n_entry = entry[g+1];
      end

      slirf_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .valid      (valid[g]),
        .prev_ins   (p_ins),
        .prev_entry (p_entry),
        .next_entry (n_entry),
        .entry      (entry[g]),
        .ins        (ins[g]),
        .eq         (eq[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rm_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (op)
      OP_INSERT: status_nxt = full ? ST_FULL : ST_OK;
      OP_REMOVE: status_nxt = found ? ST_OK : ST_MISSING;
      OP_FIND:   status_nxt = found ? ST_OK : ST_MISSING;
      default:   status_nxt = ST_MISSING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ecount_r <= COUNT_OUT_W'(count_nxt);
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = ecount_r;

endmodule

// ===== sim/tb_sorted_list_insert_remove_find_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove_find_top
// Self-checking bench for the sorted list block. A directed table covers the
// empty store, the value extremes, duplicates, a full store and the unused
// operation code. Random traffic follows, swinging between filling and
// draining. Each result word is checked against a queue-based shadow list or a pinned table row.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_remove_find_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slirf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 365;
  localparam int DIR_ROWS       = 26;

  typedef struct packed {
    op_t                    op;
    value_t                 value;
    logic                   pinned;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] count;
  } list_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_operation;
  value_t                 in_value;
  logic                   out_strobe;
  logic [1:0]             out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  value_t       shadow_list[$];
  list_result_t pending_results[$];

  logic                   pin_valid;
  logic [1:0]             pin_status;
  logic [COUNT_OUT_W-1:0] pin_count;

  int errors;
  int idle_cycles;
  int words_sent;
  int results_seen;
  int full_hits;
  int missing_hits;
  int peak_fill;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_FIND,   32'sd0,          1'b1, ST_MISSING, 5'd0},
    '{OP_REMOVE, -32'sd1,         1'b1, ST_MISSING, 5'd0},
    '{OP_NONE,   32'sd0,          1'b1, ST_MISSING, 5'd0},
    '{OP_INSERT, 32'sh7fffffff,   1'b1, ST_OK,      5'd1},
    '{OP_INSERT, 32'sh80000000,   1'b1, ST_OK,      5'd2},
    '{OP_INSERT, 32'sd0,          1'b1, ST_OK,      5'd3},
    '{OP_INSERT, 32'sd0,          1'b1, ST_OK,      5'd4},
    '{OP_FIND,   32'sh80000000,   1'b1, ST_OK,      5'd4},
    '{OP_REMOVE, 32'sd0,          1'b1, ST_OK,      5'd3},
    '{OP_FIND,   32'sd0,          1'b0, ST_OK,      5'd0},
    '{OP_INSERT, -32'sd7,         1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd100,        1'b0, ST_OK,      5'd0},
    '{OP_INSERT, -32'sd100,       1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd3,          1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd3,          1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd55555,      1'b0, ST_OK,      5'd0},
    '{OP_INSERT, -32'sd1,         1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sh40000000,   1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'shc0000000,   1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd2,          1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd7,          1'b0, ST_OK,      5'd0},
    '{OP_INSERT, 32'sd9,          1'b1, ST_OK,      5'd15},
    '{OP_INSERT, -32'sd2,         1'b1, ST_OK,      5'd16},
    '{OP_INSERT, 32'sd1,          1'b1, ST_FULL,    5'd16},
    '{OP_INSERT, 32'sd1,          1'b1, ST_FULL,    5'd16},
    '{OP_REMOVE, 32'sh7fffffff,   1'b1, ST_OK,      5'd15}
  };

  sorted_list_insert_remove_find_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_result_t sorted_list_apply(input logic [1:0] op, input value_t v);
    list_result_t res;
    int pos;
    res.status = ST_MISSING;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_list.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
          shadow_list.insert(pos, v);
          res.status = ST_OK;
        end
      end
      OP_REMOVE: begin
        while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
        if (pos < shadow_list.size()) begin
          shadow_list.delete(pos);
          res.status = ST_OK;
        end
      end
      OP_FIND: begin
        foreach (shadow_list[i]) if (shadow_list[i] == v) res.status = ST_OK;
      end
      default: res.status = ST_MISSING;
    endcase
    res.count = COUNT_OUT_W'(shadow_list.size());
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    list_result_t exp_r;
    list_result_t pred_r;
    if (rst_n) begin
      if (out_strobe) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: status %0d count %0d",
                 out_status, out_entry_count);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            errors++;
          end
          if (out_entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, out_entry_count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        words_sent++;
        pred_r = sorted_list_apply(in_operation, in_value);
        if (pred_r.status == ST_FULL) full_hits++;
        if (pred_r.status == ST_MISSING) missing_hits++;
        if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();
        if (pin_valid) begin
          exp_r.status = pin_status;
          exp_r.count  = pin_count;
          pending_results.push_back(exp_r);
        end else begin
          pending_results.push_back(pred_r);
        end
      end
      if ((start && !busy) || out_strobe) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input value_t v, input logic pinned,
                           input logic [1:0] st, input logic [COUNT_OUT_W-1:0] cnt,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    pin_valid  = pinned;
    pin_status = st;
    pin_count  = cnt;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return value_t'(int'($urandom_range(16)) - 8);
    if (r < 80 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return value_t'($urandom);
  endfunction

  function automatic logic [1:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 60 : 20)) return OP_INSERT;
    if (r < 68) return OP_REMOVE;
    if (r < 96) return OP_FIND;
    return OP_NONE;
  endfunction

  initial begin : stimulus
    int idle_pct [4] = '{0, 86, 8, 0};
    bit filling;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_INSERT;
    in_value     = '0;
    pin_valid    = 1'b0;
    pin_status   = ST_OK;
    pin_count    = '0;
    errors       = 0;
    idle_cycles  = 0;
    words_sent   = 0;
    results_seen = 0;
    full_hits    = 0;
    missing_hits = 0;
    peak_fill    = 0;
    filling      = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].pinned,
                dir_rows[i].status, dir_rows[i].count, 0);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 50 == 0) filling = ~filling;
        send_word(pick_op(filling), pick_value(), 1'b0, ST_OK, '0, idle_pct[ph]);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d words (%0d results) over four idle patterns,", words_sent,
             results_seen);
    $display("with %0d full-store drops, %0d misses and a peak fill of %0d.", full_hits,
             missing_hits, peak_fill);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
